FILE: rtl/crat_pkg.sv
package crat_pkg;

  localparam int CONN_SLOTS_DEF   = 64;
  localparam int WINDOW_DEPTH_DEF = 1024;

  localparam int ID_W    = 64;
  localparam int CNT_W   = 32;
  localparam int AVG_W   = 39;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_OPEN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSE   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
  } crat_evt_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              gauge_valid;
    logic [AVG_W-1:0]  avg;
  } crat_res_t;

endpackage

FILE: rtl/crat_fifo.sv
module crat_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  crat_pkg::crat_evt_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crat_pkg::crat_evt_t out_data
);
  import crat_pkg::*;

  crat_evt_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic do_wr;
  logic do_rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

FILE: rtl/crat_div.sv
module crat_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  q;
  logic [DEN_W:0]    rem;
  logic [DEN_W-1:0]  d;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign diff  = trial - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff;
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/crat_exec.sv
module crat_exec #(
  parameter int CONN_SLOTS   = crat_pkg::CONN_SLOTS_DEF,
  parameter int WINDOW_DEPTH = crat_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  input  crat_pkg::crat_evt_t evt,
  output logic                res_valid,
  input  logic                res_ready,
  output crat_pkg::crat_res_t res
);
  import crat_pkg::*;

  localparam int SLOT_W = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
  localparam int SCNT_W = $clog2(CONN_SLOTS + 1);
  localparam int WIN_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = CNT_W + FILL_W;
  localparam int NUM_W  = SUM_W + 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_APPLY = 7'b0000100,
    S_WRD   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [ID_W-1:0]  slot_ids    [CONN_SLOTS];
  logic [CNT_W-1:0] slot_counts [CONN_SLOTS];
  logic [CNT_W-1:0] window_counts [WINDOW_DEPTH];
  logic [CONN_SLOTS-1:0] slot_valid;

  logic [WIN_W-1:0]  window_head;
  logic [FILL_W-1:0] window_fill;
  logic [SUM_W-1:0]  window_sum;

  crat_evt_t         cur;
  logic [SCNT_W-1:0] scan;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [ID_W-1:0]   rd_id;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_ok;
  logic [CNT_W-1:0]  close_cnt;
  logic [CNT_W-1:0]  old_cnt;

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [NUM_W-1:0] num;

  assign evt_ready = (state == S_IDLE) && !res_valid;
  assign num = NUM_W'({window_sum, 6'b0}) + NUM_W'({window_sum, 5'b0})
             + NUM_W'({window_sum, 2'b0});
  assign div_start = (state == S_SUM) && !div_busy;

  crat_div #(.NUM_W(NUM_W), .DEN_W(FILL_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (window_fill),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    rd_id  <= slot_ids[scan[SLOT_W-1:0]];
    rd_cnt <= slot_counts[scan[SLOT_W-1:0]];
    rd_ok  <= slot_valid[scan[SLOT_W-1:0]] && (scan < SCNT_W'(CONN_SLOTS));
    old_cnt <= window_counts[window_head];
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY && hit && cur.mode == MODE_REQUEST) begin
      slot_counts[hit_slot] <= close_cnt + 1'b1;
    end else if (state == S_APPLY && cur.mode == MODE_OPEN && (hit || free_found)) begin
      slot_counts[hit ? hit_slot : free_slot] <= '0;
      slot_ids[hit ? hit_slot : free_slot]    <= cur.id;
    end
    if (state == S_SUM) begin
      window_counts[window_head] <= close_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      window_head <= '0;
      window_fill <= '0;
      window_sum  <= '0;
      res_valid   <= 1'b0;
      scan        <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (evt_valid && evt_ready) begin
            cur        <= evt;
            scan       <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan != '0) begin
            if (rd_ok && rd_id == cur.id && !hit) begin
              hit       <= 1'b1;
              hit_slot  <= SLOT_W'(scan - 1'b1);
              close_cnt <= rd_cnt;
            end
            if (!rd_ok && !free_found && (scan - 1'b1) < SCNT_W'(CONN_SLOTS)) begin
              free_found <= 1'b1;
              free_slot  <= SLOT_W'(scan - 1'b1);
            end
          end
          if (scan == SCNT_W'(CONN_SLOTS)) begin
            state <= S_APPLY;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_APPLY: begin
          res.gauge_valid <= 1'b0;
          res.avg         <= '0;
          res.status      <= STAT_OK;
          state           <= S_OUT;
          case (cur.mode)
            MODE_OPEN: begin
              if (hit) slot_valid[hit_slot] <= 1'b1;
              else if (free_found) slot_valid[free_slot] <= 1'b1;
              else res.status <= STAT_FULL;
            end
            MODE_REQUEST: begin
              if (!hit) res.status <= STAT_UNKNOWN;
            end
            MODE_CLOSE: begin
              if (!hit) res.status <= STAT_UNKNOWN;
              else begin
                slot_valid[hit_slot] <= 1'b0;
                state <= S_WRD;
              end
            end
            default: ;
          endcase
        end
        S_WRD: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res.gauge_valid <= 1'b1;
            res.avg         <= AVG_W'(div_quo);
            state           <= S_OUT;
          end
        end
        S_OUT: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_WRD) begin
        if (window_fill == FILL_W'(WINDOW_DEPTH)) begin
          window_sum <= window_sum - SUM_W'(old_cnt) + SUM_W'(close_cnt);
        end else begin
          window_sum  <= window_sum + SUM_W'(close_cnt);
          window_fill <= window_fill + 1'b1;
        end
      end
      if (state == S_SUM) begin
        window_head <= (window_head == WIN_W'(WINDOW_DEPTH - 1)) ? '0 : window_head + 1'b1;
      end
    end
  end
endmodule

FILE: rtl/connection_request_average_tracker.sv
// Each event runs a scan of the slot table (one slot read per cycle); a close
// also runs the gauge divider (one quotient bit per cycle).
// The engine takes one event at a time, set by the slot table scan and the serial
// divider, and accepts no new event until the last result has been taken.
// Reset: synchronous, clears slot valid bits, window head, fill and sum.
module connection_request_average_tracker #(
  parameter int CONN_SLOTS   = crat_pkg::CONN_SLOTS_DEF,
  parameter int WINDOW_DEPTH = crat_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  input  logic [63:0] s_axis_tdata,   // id[63:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,   // gauge_valid[0]
  output logic [47:0] m_axis_tdata    // status[1:0], average_times_100[40:2], zero pad
);
  import crat_pkg::*;

  crat_evt_t in_evt;
  crat_evt_t q_evt;
  crat_res_t res;
  logic      q_valid;
  logic      q_ready;

  assign in_evt.mode = s_axis_tuser;
  assign in_evt.id   = s_axis_tdata;

  crat_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_evt),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_evt)
  );

  crat_exec #(.CONN_SLOTS(CONN_SLOTS), .WINDOW_DEPTH(WINDOW_DEPTH)) u_exec (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (q_valid),
    .evt_ready (q_ready),
    .evt       (q_evt),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tuser = res.gauge_valid;
  assign m_axis_tdata = {7'b0, res.avg, res.status};
endmodule

FILE: rtl/crat_checker.sv
module crat_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tuser,
  input logic [47:0] m_axis_tdata
);
  import crat_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result dropped while stalled");

  a_gauge_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[40:2] == '0)
    else $error("gauge nonzero without valid");

  a_gauge_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == STAT_OK)
    else $error("gauge with error status");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:41] == '0)
    else $error("pad bits set");
endmodule

bind connection_request_average_tracker crat_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
